/* hw/rtl/sat_pkg.sv */
// Shared constants for the summed-area table block: field widths, default sizes,
// register indexes and result codes. Depends on nothing.
`timescale 1ns / 1ps

package sat_pkg;

	localparam int MAX_ROWS_DEF     = 64;
	localparam int MAX_COLS_DEF     = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int CFG_W    = 7;
	localparam int COORD_W  = 7;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_COLS_IN_USE = 1'b1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic KIND_PREFIX = 1'b0;
	localparam logic KIND_RECT   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_COORD  = 2'd2;

endpackage

/* hw/rtl/sat_mem.sv */
// Prefix table storage: one write port and two read ports with registered read data.
// Depends on sat_pkg for the word width.
`timescale 1ns / 1ps

module sat_mem import sat_pkg::*; #(
	parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [SUM_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [SUM_W-1:0] rdata_a,
	output logic [SUM_W-1:0] rdata_b
);

	logic [SUM_W-1:0] mem [DEPTH];
	logic [SUM_W-1:0] rdata_a_q;
	logic [SUM_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* hw/rtl/summed_area_table_range_sum.sv */
// Top level of the summed-area table: load sequencing, rectangle-sum queries, config.
// Depends on sat_pkg and sat_mem.
`timescale 1ns / 1ps

// Loads bring elements in raster order; each passes through ST_LOAD, where its prefix
// value is written to the table and registered as the result, and the block takes the
// next item in the cycle in which that result appears. A query uses both of the table's
// read ports at the start beat and again in ST_QRD, then forms its rectangle sum in
// ST_QSUM, where the block already takes the next item. The done strobe lasts one cycle
// and cannot be held off. Table entries are undefined after reset; no query result
// uses them before a full table has been loaded, so there is no clearing pass.
module summed_area_table_range_sum import sat_pkg::*; #(
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int MAX_COLS     = MAX_COLS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       opcode,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic [COORD_W-1:0]         corner_a_row,
	input  logic [COORD_W-1:0]         corner_a_col,
	input  logic [COORD_W-1:0]         corner_b_row,
	input  logic [COORD_W-1:0]         corner_b_col,
	output logic                       done,
	output logic                       result_kind,
	output logic signed [SUM_W-1:0]    sum_value,
	output logic [STATUS_W-1:0]        status,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int RW0   = $clog2(MAX_ROWS + 1);
	localparam int CW0   = $clog2(MAX_COLS + 1);
	localparam int DW1   = (RW0 > CW0) ? RW0 : CW0;
	localparam int DW    = (DW1 > COORD_W) ? DW1 : COORD_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [DW-1:0] ROWS_MAX = DW'(MAX_ROWS);
	localparam logic [DW-1:0] COLS_MAX = DW'(MAX_COLS);

	localparam logic [SUM_W-1:0] SMASK = (SAMPLE_WIDTH >= SUM_W) ? {SUM_W{1'b1}} :
		SUM_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_QRD  = 2'd2;
	localparam logic [1:0] ST_QSUM = 2'd3;

	function automatic logic [AW-1:0] tab_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
		tab_addr = AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	logic [1:0]       state_q;
	logic [DW-1:0]    rows_q;
	logic [DW-1:0]    cols_q;
	logic [DW-1:0]    load_row_q;
	logic [DW-1:0]    load_col_q;
	logic [SUM_W-1:0] run_q;
	logic             complete_q;
	logic             done_q;
	logic             kind_q;
	logic [SUM_W-1:0] sum_q;
	logic [STATUS_W-1:0] status_q;

	logic [DW-1:0]       ld_row_s1;
	logic [DW-1:0]       ld_col_s1;
	logic [SUM_W-1:0]    ld_run_s1;
	logic                ld_above_s1;
	logic [COORD_W-1:0]  q_rlo_s1;
	logic [COORD_W-1:0]  q_clo_s1;
	logic [COORD_W-1:0]  q_chi_s1;
	logic [STATUS_W-1:0] q_status_s1;
	logic                q_use_b_s1;
	logic [SUM_W-1:0]    partial_s2;

	logic                accept;
	logic                is_load;
	logic [DW-1:0]       eff_row;
	logic [DW-1:0]       eff_col;
	logic [SUM_W-1:0]    eff_run;
	logic [SUM_W-1:0]    sample_ext;
	logic [COORD_W-1:0]  r_lo, r_hi, c_lo, c_hi;
	logic                coord_bad;
	logic [STATUS_W-1:0] q_status;
	logic [DW-1:0]       cfg_dim;
	logic [DW-1:0]       cfg_clamped_rows;
	logic [DW-1:0]       cfg_clamped_cols;
	logic                rd_en;
	logic [AW-1:0]       raddr_a;
	logic [AW-1:0]       raddr_b;
	logic [SUM_W-1:0]    rdata_a;
	logic [SUM_W-1:0]    rdata_b;
	logic                wr_en;
	logic [AW-1:0]       waddr;
	logic [SUM_W-1:0]    load_sum;
	logic [DW-1:0]       col_next;
	logic [DW-1:0]       row_next;
	logic                row_wrap;
	logic                tab_wrap;
	logic                q_use_c;
	logic                q_use_d;
	logic [SUM_W-1:0]    rect_sum;

	assign busy    = (state_q == ST_LOAD) || (state_q == ST_QRD);
	assign accept  = start && !busy;
	assign is_load = (opcode == OP_LOAD);

	assign eff_row = complete_q ? '0 : load_row_q;
	assign eff_col = complete_q ? '0 : load_col_q;
	assign eff_run = complete_q ? '0 : run_q;

	always_comb begin
		sample_ext = {{(SUM_W - SAMPLE_W){1'b0}}, sample_value} & SMASK;
		if (sample_ext[SAMPLE_WIDTH-1]) begin
			sample_ext = sample_ext | ~SMASK;
		end
	end

	assign r_lo = (corner_a_row > corner_b_row) ? corner_b_row : corner_a_row;
	assign r_hi = (corner_a_row > corner_b_row) ? corner_a_row : corner_b_row;
	assign c_lo = (corner_a_col > corner_b_col) ? corner_b_col : corner_a_col;
	assign c_hi = (corner_a_col > corner_b_col) ? corner_a_col : corner_b_col;

	assign coord_bad = (corner_a_row == '0) || (corner_b_row == '0) ||
		(corner_a_col == '0) || (corner_b_col == '0) ||
		(DW'(corner_a_row) > rows_q) || (DW'(corner_b_row) > rows_q) ||
		(DW'(corner_a_col) > cols_q) || (DW'(corner_b_col) > cols_q);

	always_comb begin
		priority if (!complete_q) begin
			q_status = STATUS_NOT_LOADED;
		end else if (coord_bad) begin
			q_status = STATUS_BAD_COORD;
		end else begin
			q_status = STATUS_OK;
		end
	end

	assign cfg_dim = DW'(cfg_data);
	assign cfg_clamped_rows = (cfg_dim == '0) ? DW'(1) : (cfg_dim > ROWS_MAX) ? ROWS_MAX : cfg_dim;
	assign cfg_clamped_cols = (cfg_dim == '0) ? DW'(1) : (cfg_dim > COLS_MAX) ? COLS_MAX : cfg_dim;

	// Port A and B addresses: the row above for a load, two corners per query cycle.
	always_comb begin
		rd_en = accept || (state_q == ST_QRD);
		priority if (state_q == ST_QRD) begin
			raddr_a = tab_addr(DW'(q_rlo_s1) - DW'(2), DW'(q_chi_s1) - DW'(1));
			raddr_b = tab_addr(DW'(q_rlo_s1) - DW'(2), DW'(q_clo_s1) - DW'(2));
		end else if (is_load) begin
			raddr_a = tab_addr(eff_row - DW'(1), eff_col);
			raddr_b = raddr_a;
		end else begin
			raddr_a = tab_addr(DW'(r_hi) - DW'(1), DW'(c_hi) - DW'(1));
			raddr_b = tab_addr(DW'(r_hi) - DW'(1), DW'(c_lo) - DW'(2));
		end
	end

	assign wr_en    = (state_q == ST_LOAD);
	assign waddr    = tab_addr(ld_row_s1, ld_col_s1);
	assign load_sum = ld_run_s1 + (ld_above_s1 ? rdata_a : '0);
	assign col_next = ld_col_s1 + DW'(1);
	assign row_next = ld_row_s1 + DW'(1);
	assign row_wrap = (col_next >= cols_q);
	assign tab_wrap = row_wrap && (row_next >= rows_q);

	assign q_use_c  = (q_rlo_s1 >= COORD_W'(2));
	assign q_use_d  = q_use_c && (q_clo_s1 >= COORD_W'(2));
	assign rect_sum = partial_s2 - (q_use_c ? rdata_a : '0) + (q_use_d ? rdata_b : '0);

	sat_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (waddr),
		.wdata  (load_sum),
		.re     (rd_en),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rows_q     <= ROWS_MAX;
			cols_q     <= COLS_MAX;
			load_row_q <= '0;
			load_col_q <= '0;
			run_q      <= '0;
			complete_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				if (cfg_index == REG_ROWS_IN_USE) begin
					rows_q <= cfg_clamped_rows;
				end else begin
					cols_q <= cfg_clamped_cols;
				end
				load_row_q <= '0;
				load_col_q <= '0;
				run_q      <= '0;
				complete_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (row_wrap) begin
						load_col_q <= '0;
						run_q      <= '0;
						load_row_q <= tab_wrap ? '0 : row_next;
						complete_q <= tab_wrap;
					end else begin
						load_col_q <= col_next;
						load_row_q <= ld_row_s1;
						run_q      <= ld_run_s1;
					end
				end
				ST_QRD: begin
					state_q <= ST_QSUM;
				end
				ST_IDLE, ST_QSUM: begin
					if (state_q == ST_QSUM) begin
						done_q <= 1'b1;
					end
					if (accept) begin
						state_q <= is_load ? ST_LOAD : ST_QRD;
						if (is_load) begin
							complete_q <= 1'b0;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_row_s1   <= eff_row;
			ld_col_s1   <= eff_col;
			ld_run_s1   <= eff_run + sample_ext;
			ld_above_s1 <= (eff_row != '0);
			q_rlo_s1    <= r_lo;
			q_clo_s1    <= c_lo;
			q_chi_s1    <= c_hi;
			q_status_s1 <= q_status;
			q_use_b_s1  <= (c_lo >= COORD_W'(2));
		end
		if (state_q == ST_QRD) begin
			partial_s2 <= rdata_a - (q_use_b_s1 ? rdata_b : '0);
		end
		if (state_q == ST_LOAD) begin
			kind_q   <= KIND_PREFIX;
			sum_q    <= load_sum;
			status_q <= STATUS_OK;
		end else if (state_q == ST_QSUM) begin
			kind_q   <= KIND_RECT;
			sum_q    <= (q_status_s1 == STATUS_OK) ? rect_sum : '0;
			status_q <= q_status_s1;
		end
	end

	assign done        = done_q;
	assign result_kind = kind_q;
	assign sum_value   = sum_q;
	assign status      = status_q;

	a_load_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_load) |=> ##1 (done && result_kind == KIND_PREFIX))
		else $error("load beat did not return its prefix two cycles later");

	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_load) |=> ##2 (done && result_kind == KIND_RECT))
		else $error("query beat did not return its sum three cycles later");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (sum_value == '0))
		else $error("failed query returned a nonzero sum");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_LOAD || $past(state_q) == ST_QSUM))
		else $error("done raised outside a result cycle");

endmodule

/* tb/summed_area_table_range_sum_test.sv */
// Self-checking test of summed_area_table_range_sum: loads tables in raster order, runs
// rectangle-sum queries and register writes, and checks every result beat against a predictor.
// Depends on sat_pkg and the summed_area_table_range_sum RTL.
`timescale 1ns / 1ps

module summed_area_table_range_sum_test;
	import sat_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic                kind;
		logic [SUM_W-1:0]    sum;
		logic [STATUS_W-1:0] code;
	} sat_result_t;

	class range_sum_predictor;
		logic [SUM_W-1:0] prefix_mem [MAX_ROWS_DEF*MAX_COLS_DEF];
		logic [SUM_W-1:0] row_sum;
		int load_row;
		int load_col;
		int rows;
		int cols;
		bit complete;
		sat_result_t pending_sums[$];
		int mismatches;

		function new();
			rows = MAX_ROWS_DEF;
			cols = MAX_COLS_DEF;
			mismatches = 0;
			restart_load();
		endfunction

		function void restart_load();
			row_sum = '0;
			load_row = 0;
			load_col = 0;
			complete = 1'b0;
		endfunction

		function void take_config(logic idx, logic [CFG_W-1:0] raw);
			int dim;
			dim = (raw == 0) ? 1 : int'(raw);
			if (idx == REG_ROWS_IN_USE) begin
				rows = (dim > MAX_ROWS_DEF) ? MAX_ROWS_DEF : dim;
			end else begin
				cols = (dim > MAX_COLS_DEF) ? MAX_COLS_DEF : dim;
			end
			restart_load();
		endfunction

		function int loads_left();
			return complete ? rows * cols : rows * cols - (load_row * cols + load_col);
		endfunction

		// Coordinates are one-based; row or column zero reads as zero.
		function logic [SUM_W-1:0] entry_at(int row, int col);
			if (row == 0 || col == 0) begin
				return '0;
			end
			return prefix_mem[(row - 1) * MAX_COLS_DEF + col - 1];
		endfunction

		function void take_item(logic op, logic [SAMPLE_W-1:0] smp, logic [COORD_W-1:0] ar,
				logic [COORD_W-1:0] ac, logic [COORD_W-1:0] br, logic [COORD_W-1:0] bc);
			sat_result_t res;
			logic [SUM_W-1:0] above;
			int r1;
			int c1;
			int r2;
			int c2;
			int t;
			res.kind = (op == OP_QUERY) ? KIND_RECT : KIND_PREFIX;
			res.sum = '0;
			res.code = STATUS_OK;
			if (op == OP_LOAD) begin
				if (complete) begin
					restart_load();
				end
				row_sum = row_sum + {{(SUM_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
				above = (load_row > 0) ? entry_at(load_row, load_col + 1) : '0;
				res.sum = row_sum + above;
				prefix_mem[load_row * MAX_COLS_DEF + load_col] = res.sum;
				load_col++;
				if (load_col >= cols) begin
					load_col = 0;
					row_sum = '0;
					load_row++;
					if (load_row >= rows) begin
						load_row = 0;
						complete = 1'b1;
					end
				end
			end else if (!complete) begin
				res.code = STATUS_NOT_LOADED;
			end else begin
				r1 = int'(ar);
				c1 = int'(ac);
				r2 = int'(br);
				c2 = int'(bc);
				if (r1 == 0 || r2 == 0 || c1 == 0 || c2 == 0 || r1 > rows || r2 > rows ||
						c1 > cols || c2 > cols) begin
					res.code = STATUS_BAD_COORD;
				end else begin
					if (r1 > r2) begin
						t = r1;
						r1 = r2;
						r2 = t;
					end
					if (c1 > c2) begin
						t = c1;
						c1 = c2;
						c2 = t;
					end
					res.sum = entry_at(r2, c2) - entry_at(r2, c1 - 1) - entry_at(r1 - 1, c2)
						+ entry_at(r1 - 1, c1 - 1);
				end
			end
			pending_sums.push_back(res);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		function void match_result(logic kind, logic [SUM_W-1:0] sum, logic [STATUS_W-1:0] code);
			sat_result_t want;
			if (pending_sums.size() == 0) begin
				flag($sformatf("unexpected result beat: kind %0d sum %0d status %0d",
					kind, $signed(sum), code));
				return;
			end
			want = pending_sums.pop_front();
			if (want.kind !== kind || want.sum !== sum || want.code !== code) begin
				flag($sformatf("expected kind %0d sum %0d status %0d, got kind %0d sum %0d status %0d",
					want.kind, $signed(want.sum), want.code, kind, $signed(sum), code));
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       opcode = OP_LOAD;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic [COORD_W-1:0]         corner_a_row = '0;
	logic [COORD_W-1:0]         corner_a_col = '0;
	logic [COORD_W-1:0]         corner_b_row = '0;
	logic [COORD_W-1:0]         corner_b_col = '0;
	logic                       done;
	logic                       result_kind;
	logic signed [SUM_W-1:0]    sum_value;
	logic [STATUS_W-1:0]        status;
	logic                       cfg_write = 1'b0;
	logic                       cfg_index = REG_ROWS_IN_USE;
	logic [CFG_W-1:0]           cfg_data = '0;

	range_sum_predictor predictor;
	int idle_pct = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	int idle_plan [3] = '{0, 70, 29};
	int rows_plan [8] = '{0, 64, 127, 3, 5, 2, 90, 4};
	int cols_plan [8] = '{127, 1, 2, 4, 3, 6, 2, 0};

	summed_area_table_range_sum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.sample_value (sample_value),
		.corner_a_row (corner_a_row),
		.corner_a_col (corner_a_col),
		.corner_b_row (corner_b_row),
		.corner_b_col (corner_b_col),
		.done         (done),
		.result_kind  (result_kind),
		.sum_value    (sum_value),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			predictor.match_result(result_kind, sum_value, status);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_write) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("summed_area_table_range_sum_test: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Returns at the edge that accepts the beat; start stays high for a following beat.
	task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] smp,
			input logic [COORD_W-1:0] ar, input logic [COORD_W-1:0] ac,
			input logic [COORD_W-1:0] br, input logic [COORD_W-1:0] bc);
		int gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(15) == 0) begin
			burst_left = $urandom_range(8, 30);
		end else if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		sample_value <= smp;
		corner_a_row <= ar;
		corner_a_col <= ac;
		corner_b_row <= br;
		corner_b_col <= bc;
		@(posedge clk);
		while (busy) @(posedge clk);
		predictor.take_item(op, smp, ar, ac, br, bc);
	endtask

	task automatic load_value(input logic [SAMPLE_W-1:0] smp);
		send_beat(OP_LOAD, smp, COORD_W'($urandom_range(0, 127)),
			COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)),
			COORD_W'($urandom_range(0, 127)));
	endtask

	task automatic rand_query();
		if ($urandom_range(99) < 85) begin
			send_beat(OP_QUERY, SAMPLE_W'($urandom), COORD_W'($urandom_range(1, predictor.rows)),
				COORD_W'($urandom_range(1, predictor.cols)),
				COORD_W'($urandom_range(1, predictor.rows)),
				COORD_W'($urandom_range(1, predictor.cols)));
		end else begin
			send_beat(OP_QUERY, SAMPLE_W'($urandom), COORD_W'($urandom_range(0, 127)),
				COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)),
				COORD_W'($urandom_range(0, 127)));
		end
	endtask

	task automatic write_dims(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw);
		start <= 1'b0;
		while (predictor.pending_sums.size() != 0 || busy) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_ROWS_IN_USE;
		cfg_data <= rows_raw;
		@(posedge clk);
		predictor.take_config(REG_ROWS_IN_USE, rows_raw);
		cfg_index <= REG_COLS_IN_USE;
		cfg_data <= cols_raw;
		@(posedge clk);
		predictor.take_config(REG_COLS_IN_USE, cols_raw);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int count;
		int n;
		predictor = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(OP_QUERY, 16'h1234, 1, 1, 64, 64);
		load_value(16'h7FFF);
		write_dims(2, 3);
		load_value(16'h7FFF);
		load_value(16'h8000);
		load_value(16'hFFFF);
		// An incomplete table wins over a bad coordinate.
		send_beat(OP_QUERY, 16'h0000, 0, 0, 0, 0);
		load_value(16'h0000);
		load_value(16'h5555);
		load_value(16'hAAAA);
		send_beat(OP_QUERY, 16'hFFFF, 1, 1, 2, 3);
		send_beat(OP_QUERY, 16'h0000, 2, 3, 1, 1);
		send_beat(OP_QUERY, 16'h8000, 2, 2, 2, 2);
		send_beat(OP_QUERY, 16'h7FFF, 1, 3, 2, 1);
		send_beat(OP_QUERY, 16'h0000, 0, 1, 1, 1);
		send_beat(OP_QUERY, 16'h0000, 3, 1, 1, 1);
		send_beat(OP_QUERY, 16'h0000, 1, 4, 1, 1);
		send_beat(OP_QUERY, 16'h0000, 1, 1, 2, 0);
		send_beat(OP_QUERY, 16'h0000, 127, 127, 127, 127);
		load_value(16'h8000);
		send_beat(OP_QUERY, 16'hFFFF, 1, 1, 1, 1);

		for (phase = 0; phase < 10; phase++) begin
			idle_pct = idle_plan[phase % 3];
			if (phase < 8) begin
				write_dims(CFG_W'(rows_plan[phase]), CFG_W'(cols_plan[phase]));
			end else begin
				write_dims(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)));
			end
			count = 0;
			while (count < 110) begin
				if ($urandom_range(9) == 0) begin
					n = $urandom_range(0, predictor.loads_left() - 1);
					repeat (n) load_value(random_sample());
					rand_query();
					count += n + 1;
				end else begin
					n = predictor.loads_left();
					repeat (n) load_value(random_sample());
					count += n;
					n = $urandom_range(3, 12);
					repeat (n) rand_query();
					count += n;
				end
			end
		end

		start <= 1'b0;
		while (predictor.pending_sums.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (predictor.mismatches == 0 && predictor.pending_sums.size() == 0) begin
			$display("summed_area_table_range_sum_test: done, clean");
		end else begin
			$display("summed_area_table_range_sum_test: done, errors");
		end
		$finish;
	end

endmodule
